// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property at every rising edge of clk_i, outside reset.
`define PAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds.
`define PAC_ASSERT_NEVER(lbl, cond, msg) `PAC_ASSERT(lbl, !(cond), msg)
`else
`define PAC_ASSERT(lbl, prop, msg)
`define PAC_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: sv/pac_pkg.sv
`timescale 1ns / 1ps

package pac_pkg;

  // Request and result payloads
  typedef struct packed {
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
  } pac_in_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
  } pac_out_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_ACCEL_MODE      = 3'd0;
  localparam logic [2:0] CFG_BOUND_MIN_X     = 3'd1;
  localparam logic [2:0] CFG_BOUND_MAX_X     = 3'd2;
  localparam logic [2:0] CFG_BOUND_MIN_Y     = 3'd3;
  localparam logic [2:0] CFG_BOUND_MAX_Y     = 3'd4;
  localparam logic [2:0] CFG_RADIAL_CENTER_X = 3'd5;
  localparam logic [2:0] CFG_RADIAL_CENTER_Y = 3'd6;
  localparam logic [2:0] CFG_RADIAL_RADIUS   = 3'd7;

  // Acceleration modes
  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_FAST = 2'd2;

  // Reset values
  localparam logic [1:0]         RST_ACCEL_MODE  = MODE_FAST;
  localparam logic signed [15:0] RST_BOUND_MIN_X = 16'sd0;
  localparam logic signed [15:0] RST_BOUND_MAX_X = 16'sd10240;
  localparam logic signed [15:0] RST_BOUND_MIN_Y = 16'sd0;
  localparam logic signed [15:0] RST_BOUND_MAX_Y = 16'sd7680;
  localparam logic signed [15:0] RST_CENTER      = 16'sd0;
  localparam logic signed [15:0] RST_RADIUS      = -16'sd1;

  // Acceleration thresholds on |delta|
  localparam logic [16:0] SLOW_THRESHOLD = 17'd160;
  localparam logic [16:0] FAST_THRESHOLD = 17'd320;

  // Root/divide unit sizing
  localparam int unsigned UNIT_W     = 35;
  localparam int unsigned SQRT_STEPS = 17;
  localparam int unsigned DIV_STEPS  = 15;

  typedef enum logic {
    OP_SQRT,
    OP_DIV
  } pac_op_e;

  typedef struct packed {
    logic    start;
    pac_op_e op;
  } pac_unit_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [16:0] result;
  } pac_unit_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_VEC,
    ST_MUL,
    ST_CMP,
    ST_SQRT,
    ST_DIVX,
    ST_DIVY,
    ST_FIX,
    ST_DONE
  } pac_state_e;

endpackage

// File: sv/pointer_accel_clamp.sv
`timescale 1ns / 1ps
// Threshold pointer acceleration with box clamp and radial limit.
// Requests (delta_x, delta_y in Q12.4) arrive on in_valid_i / in_stall_o; each
// is taken while the sequencer is idle. Every request gives one result
// (pos_x, pos_y), the new cursor, on out_valid_o / out_stall_i.
// Path from the accepting edge to out_valid_o high, by case:
//   radius negative (limit off)               clamp, done
//   radius set, position inside the circle    clamp, vector, multiply, compare, done
//   radius set, position pulled onto circle   as above, then root, two divides, fix
// The long case is set by the shared root/divide unit, which resolves one bit
// a cycle: 17 steps of square root then 15 quotient bits per axis. One request
// is in flight at a time and the next is taken in the idle state that follows
// the load of the result.
// The result register frees the input: a new request is taken while a result
// waits; a stalled receiver only holds the sequencer at its final state.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i), to be
// written only while idle; the block does not enforce this. Reset clears the
// cursor, loads the register defaults (fast mode, 640x480 box, limit off) and drops any result.
`include "assert_macros.svh"

module pointer_accel_clamp import pac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  pac_in_t     in_data_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output pac_out_t    out_data_o,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  // Multiplier step codes
  localparam logic [2:0] MUL_SQX  = 3'd0;
  localparam logic [2:0] MUL_SQY  = 3'd1;
  localparam logic [2:0] MUL_R2   = 3'd2;
  localparam logic [2:0] MUL_NX   = 3'd3;
  localparam logic [2:0] MUL_NY   = 3'd4;

  // Configuration registers
  logic [1:0]         mode_q;
  logic signed [15:0] min_x_q, max_x_q, min_y_q, max_y_q;
  logic signed [15:0] cen_x_q, cen_y_q, radius_q;

  // Sequencer and working registers
  pac_state_e         state_q, state_d;
  logic signed [15:0] cursor_x_q, cursor_y_q;
  logic signed [19:0] sum_x_q, sum_y_q;
  logic signed [16:0] vx_q, vy_q;
  logic signed [33:0] sqx_q, sqy_q, r2_q, nx_q, ny_q;
  logic [2:0]         mul_cnt_q;
  logic [16:0]        m_q;
  logic [14:0]        qx_q;
  logic               out_valid_q;
  pac_out_t           out_data_q;

  // Control
  logic               in_accept;
  logic               out_load;
  pac_unit_req_t      unit_req;
  pac_unit_rsp_t      unit_rsp;
  logic [UNIT_W-1:0]  unit_a;
  logic [16:0]        unit_b;

  // ------------------------------------------------------------------
  // Acceleration and accumulation, done on the accepting edge
  // ------------------------------------------------------------------
  logic               mode_on, mode_fast;
  logic [16:0]        abs_x, abs_y;
  logic signed [19:0] dx_ext, dy_ext, step_x, step_y;

  assign mode_on   = (mode_q != MODE_OFF);
  assign mode_fast = (mode_q == MODE_FAST);
  assign abs_x = in_data_i.delta_x[15] ? (~{1'b1, in_data_i.delta_x} + 17'd1)
                                       : {1'b0, in_data_i.delta_x};
  assign abs_y = in_data_i.delta_y[15] ? (~{1'b1, in_data_i.delta_y} + 17'd1)
                                       : {1'b0, in_data_i.delta_y};
  assign dx_ext = {{4{in_data_i.delta_x[15]}}, in_data_i.delta_x};
  assign dy_ext = {{4{in_data_i.delta_y[15]}}, in_data_i.delta_y};

  // X steps 4, 2 or 1; Y only 4 or 1 (the slow step scales Y by 4 as well)
  always_comb begin
    if (mode_fast && (abs_x > FAST_THRESHOLD)) begin
      step_x = dx_ext <<< 2;
    end else if (mode_on && (abs_x > SLOW_THRESHOLD)) begin
      step_x = dx_ext <<< 1;
    end else begin
      step_x = dx_ext;
    end
    if ((mode_on && (abs_y > SLOW_THRESHOLD)) || (mode_fast && (abs_y > FAST_THRESHOLD))) begin
      step_y = dy_ext <<< 2;
    end else begin
      step_y = dy_ext;
    end
  end

  // Raise to min, then lower to max: with inverted bounds max wins
  function automatic logic signed [15:0] clamp_box(input logic signed [19:0] v,
                                                   input logic signed [15:0] lo,
                                                   input logic signed [15:0] hi);
    logic signed [19:0] t;
    t = v;
    if (t < $signed({{4{lo[15]}}, lo})) t = $signed({{4{lo[15]}}, lo});
    if (t > $signed({{4{hi[15]}}, hi})) t = $signed({{4{hi[15]}}, hi});
    return t[15:0];
  endfunction

  // center + signed quotient, saturated to 16 bits
  function automatic logic signed [15:0] place(input logic signed [15:0] c,
                                               input logic [14:0] q,
                                               input logic neg);
    logic signed [17:0] off;
    logic signed [17:0] s;
    off = neg ? -$signed({3'b000, q}) : $signed({3'b000, q});
    s   = {{2{c[15]}}, c} + off;
    if (s > 18'sd32767) begin
      return 16'sh7fff;
    end else if (s < -18'sd32768) begin
      return 16'sh8000;
    end
    return s[15:0];
  endfunction

  // ------------------------------------------------------------------
  // Shared multiplier: one 17x17 product a cycle, registered per step
  // ------------------------------------------------------------------
  logic signed [16:0] mul_a, mul_b, radius_ext;
  logic signed [33:0] mul_p;

  assign radius_ext = {radius_q[15], radius_q};

  always_comb begin
    case (mul_cnt_q)
      MUL_SQX: begin mul_a = vx_q; mul_b = vx_q; end
      MUL_SQY: begin mul_a = vy_q; mul_b = vy_q; end
      MUL_R2:  begin mul_a = radius_ext; mul_b = radius_ext; end
      MUL_NX:  begin mul_a = vx_q; mul_b = radius_ext; end
      MUL_NY:  begin mul_a = vy_q; mul_b = radius_ext; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Squared distance against squared radius
  logic [UNIT_W-1:0] d2;
  logic              outside;
  logic [33:0]       nx_mag, ny_mag;

  assign d2      = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign outside = ({1'b0, r2_q} < d2);
  assign nx_mag  = nx_q[33] ? 34'(-nx_q) : 34'(nx_q);
  assign ny_mag  = ny_q[33] ? 34'(-ny_q) : 34'(ny_q);

  // ------------------------------------------------------------------
  // Sequencer: next state
  // ------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_accept) state_d = ST_CLAMP;
      ST_CLAMP: state_d = radius_q[15] ? ST_DONE : ST_VEC;
      ST_VEC:   state_d = ST_MUL;
      ST_MUL:   if (mul_cnt_q == MUL_NY) state_d = ST_CMP;
      ST_CMP:   state_d = outside ? ST_SQRT : ST_DONE;
      ST_SQRT:  if (unit_rsp.done) state_d = ST_DIVX;
      ST_DIVX:  if (unit_rsp.done) state_d = ST_DIVY;
      ST_DIVY:  if (unit_rsp.done) state_d = ST_FIX;
      ST_FIX:   state_d = ST_DONE;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------------
  // Sequencer: outputs
  // ------------------------------------------------------------------
  always_comb begin
    in_stall_o   = 1'b1;
    out_load     = 1'b0;
    unit_req     = '{start: 1'b0, op: OP_SQRT};
    unit_a       = {1'b0, nx_mag};
    unit_b       = m_q;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_CMP: begin
        unit_req = '{start: outside, op: OP_SQRT};
        unit_a   = d2;
      end
      ST_SQRT: begin
        unit_req = '{start: unit_rsp.done, op: OP_DIV};
        unit_b   = unit_rsp.result;
      end
      ST_DIVX: begin
        unit_req = '{start: unit_rsp.done, op: OP_DIV};
        unit_a   = {1'b0, ny_mag};
      end
      ST_DONE: begin
        out_load = !out_valid_q || !out_stall_i;
      end
      default: begin
      end
    endcase
  end

  assign in_accept = in_valid_i && !in_stall_o;

  pac_rootdiv u_rootdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (unit_req),
    .a_i    (unit_a),
    .b_i    (unit_b),
    .rsp_o  (unit_rsp)
  );

  // ------------------------------------------------------------------
  // Control registers: state, cursor, configuration, result valid
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cursor_x_q  <= '0;
      cursor_y_q  <= '0;
      out_valid_q <= 1'b0;
      mode_q      <= RST_ACCEL_MODE;
      min_x_q     <= RST_BOUND_MIN_X;
      max_x_q     <= RST_BOUND_MAX_X;
      min_y_q     <= RST_BOUND_MIN_Y;
      max_y_q     <= RST_BOUND_MAX_Y;
      cen_x_q     <= RST_CENTER;
      cen_y_q     <= RST_CENTER;
      radius_q    <= RST_RADIUS;
    end else begin
      state_q <= state_d;

      // Cursor doubles as the working position for the request in flight
      if (state_q == ST_CLAMP) begin
        cursor_x_q <= clamp_box(sum_x_q, min_x_q, max_x_q);
        cursor_y_q <= clamp_box(sum_y_q, min_y_q, max_y_q);
      end else if (state_q == ST_FIX) begin
        cursor_x_q <= place(cen_x_q, qx_q, nx_q[33]);
        cursor_y_q <= place(cen_y_q, unit_rsp.result[14:0], ny_q[33]);
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ACCEL_MODE:      mode_q   <= cfg_data_i[1:0];
          CFG_BOUND_MIN_X:     min_x_q  <= cfg_data_i;
          CFG_BOUND_MAX_X:     max_x_q  <= cfg_data_i;
          CFG_BOUND_MIN_Y:     min_y_q  <= cfg_data_i;
          CFG_BOUND_MAX_Y:     max_y_q  <= cfg_data_i;
          CFG_RADIAL_CENTER_X: cen_x_q  <= cfg_data_i;
          CFG_RADIAL_CENTER_Y: cen_y_q  <= cfg_data_i;
          CFG_RADIAL_RADIUS:   radius_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Multiply step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_cnt_q <= MUL_SQX;
    end else if (state_q == ST_VEC) begin
      mul_cnt_q <= MUL_SQX;
    end else if (state_q == ST_MUL) begin
      mul_cnt_q <= mul_cnt_q + 3'd1;
    end
  end

  // ------------------------------------------------------------------
  // Payload registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sum_x_q <= {{4{cursor_x_q[15]}}, cursor_x_q} + step_x;
      sum_y_q <= {{4{cursor_y_q[15]}}, cursor_y_q} + step_y;
    end
    if (state_q == ST_VEC) begin
      vx_q <= {cursor_x_q[15], cursor_x_q} - {cen_x_q[15], cen_x_q};
      vy_q <= {cursor_y_q[15], cursor_y_q} - {cen_y_q[15], cen_y_q};
    end
    if (state_q == ST_MUL) begin
      case (mul_cnt_q)
        MUL_SQX: sqx_q <= mul_p;
        MUL_SQY: sqy_q <= mul_p;
        MUL_R2:  r2_q  <= mul_p;
        MUL_NX:  nx_q  <= mul_p;
        MUL_NY:  ny_q  <= mul_p;
        default: begin
        end
      endcase
    end
    if ((state_q == ST_SQRT) && unit_rsp.done) begin
      m_q <= unit_rsp.result;
    end
    if ((state_q == ST_DIVX) && unit_rsp.done) begin
      qx_q <= unit_rsp.result[14:0];
    end
    if (out_load) begin
      out_data_q.pos_x <= cursor_x_q;
      out_data_q.pos_y <= cursor_y_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  `PAC_ASSERT(a_result_from_done, $rose(out_valid_q) |-> ($past(state_q) == ST_DONE), "result raised outside the final state")
  `PAC_ASSERT_NEVER(a_unit_no_restart, unit_req.start && unit_rsp.busy, "root/divide unit restarted while busy")
  `PAC_ASSERT(a_result_is_cursor, ((state_q == ST_DONE) && !out_valid_q) |=> (out_valid_q && (out_data_q.pos_x == $past(cursor_x_q)) && (out_data_q.pos_y == $past(cursor_y_q))), "result does not match the cursor")

endmodule

// File: sv/pac_rootdiv.sv
`timescale 1ns / 1ps

// Shared bit-serial unit: integer square root or restoring division,
// one result bit per cycle through a single compare and subtract.
module pac_rootdiv import pac_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pac_unit_req_t       req_i,
  input  logic [UNIT_W-1:0]   a_i,
  input  logic [16:0]         b_i,
  output pac_unit_rsp_t       rsp_o
);

  localparam logic [4:0] SQRT_LAST = 5'(SQRT_STEPS - 1);
  localparam logic [4:0] DIV_LAST  = 5'(DIV_STEPS - 1);

  logic              busy_q, done_q;
  pac_op_e           op_q;
  logic [4:0]        cnt_q;
  logic [UNIT_W-1:0] rem_q, res_q, bit_q, den_q;
  logic [UNIT_W-1:0] trial;
  logic              ge;

  assign trial = (op_q == OP_SQRT) ? (res_q + bit_q) : den_q;
  assign ge    = (rem_q >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= (req_i.op == OP_SQRT) ? SQRT_LAST : DIV_LAST;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q  <= req_i.op;
      rem_q <= a_i;
      res_q <= '0;
      bit_q <= UNIT_W'(1) << (2 * (SQRT_STEPS - 1));
      den_q <= UNIT_W'(b_i) << (DIV_STEPS - 1);
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - trial;
      end
      if (op_q == OP_SQRT) begin
        res_q <= ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);
        bit_q <= bit_q >> 2;
      end else begin
        res_q <= {res_q[UNIT_W-2:0], ge};
        den_q <= den_q >> 1;
      end
    end
  end

  assign rsp_o.busy   = busy_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q[16:0];

endmodule
